>>> design/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared constants for the chamfer 3-4 distance transform block.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DIST_BITS_DEF  = 10;

  // configuration register geometry
  localparam int CFG_IDX_W = 1;
  localparam int DIM_W     = 9;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // output distance field width
  localparam int OUT_DIST_W = 10;

  // chamfer step costs
  localparam int COST_W = 3;
  localparam logic [COST_W-1:0] COST_ORTH = 3'd3;
  localparam logic [COST_W-1:0] COST_DIAG = 3'd4;

endpackage

>>> design/cdt_ram.sv
// ----------------------------------------------------------------------------
// cdt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cdt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/cdt_relax.sv
// ----------------------------------------------------------------------------
// cdt_relax
// Shared relax unit: neighbour plus step cost, saturated, min with current.
// ----------------------------------------------------------------------------
module cdt_relax
  import cdt_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  logic [DIST_BITS-1:0] acc,
  input  logic [DIST_BITS-1:0] nb,
  input  logic                 nb_valid,
  input  logic [COST_W-1:0]    cost,
  output logic [DIST_BITS-1:0] res
);

  logic [DIST_BITS-1:0] nb_v;
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] sat;

  always_comb begin
    // outside the frame counts as zero
    nb_v = nb_valid ? nb : '0;
    sum  = {1'b0, nb_v} + (DIST_BITS + 1)'(cost);
    sat  = sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
    res  = (sat < acc) ? sat : acc;
  end

endmodule

>>> design/cdt_seq.sv
// ----------------------------------------------------------------------------
// cdt_seq
// Transform sequencer: forward then backward raster pass, six steps a pixel.
// ----------------------------------------------------------------------------
module cdt_seq
  import cdt_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int AW        = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIM_W-1:0]     w_in,
  input  logic [DIM_W-1:0]     h_in,
  output logic                 busy,
  output logic                 done,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [DIST_BITS-1:0] wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [DIST_BITS-1:0] rd_data
);

  localparam logic [2:0] ST_C = 3'd0;
  localparam logic [2:0] ST_A = 3'd1;
  localparam logic [2:0] ST_B = 3'd2;
  localparam logic [2:0] ST_D = 3'd3;
  localparam logic [2:0] ST_E = 3'd4;
  localparam logic [2:0] ST_W = 3'd5;

  logic                 busy_r, busy_nxt;
  logic                 bwd_r, bwd_nxt;
  logic [2:0]           ph_r, ph_nxt;
  logic [DIM_W-1:0]     x_r, x_nxt;
  logic [DIM_W-1:0]     y_r, y_nxt;
  logic [DIM_W-1:0]     w_r, w_nxt;
  logic [DIM_W-1:0]     h_r, h_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [DIST_BITS-1:0] acc_r, acc_nxt;

  logic [AW-1:0]        wa, base, n0, n1, n2, n3;
  logic                 x_first, x_last, y_first, y_last, vert_ok;
  logic                 v0, v1, v2, v3;
  logic                 rx_valid;
  logic [COST_W-1:0]    rx_cost;
  logic [DIST_BITS-1:0] rx_res;
  logic                 last_pix;

  cdt_relax #(
    .DIST_BITS (DIST_BITS)
  ) u_relax (
    .acc      (acc_r),
    .nb       (rd_data),
    .nb_valid (rx_valid),
    .cost     (rx_cost),
    .res      (rx_res)
  );

  always_comb begin
    wa      = AW'(w_r);
    base    = bwd_r ? (idx_r + wa) : (idx_r - wa);
    n0      = bwd_r ? (base + AW'(1)) : (base - AW'(1));
    n1      = base;
    n2      = bwd_r ? (base - AW'(1)) : (base + AW'(1));
    n3      = bwd_r ? (idx_r + AW'(1)) : (idx_r - AW'(1));
    x_first = (x_r == '0);
    x_last  = ((x_r + 9'd1) == w_r);
    y_first = (y_r == '0);
    y_last  = ((y_r + 9'd1) == h_r);
    vert_ok = bwd_r ? !y_last : !y_first;
    v0      = vert_ok && (bwd_r ? !x_last : !x_first);
    v1      = vert_ok;
    v2      = vert_ok && (bwd_r ? !x_first : !x_last);
    v3      = bwd_r ? !x_last : !x_first;
    last_pix = bwd_r && x_first && y_first;
  end

  always_comb begin
    busy_nxt = busy_r;
    bwd_nxt  = bwd_r;
    ph_nxt   = ph_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    rd_en    = 1'b0;
    rd_addr  = idx_r;
    wr_en    = 1'b0;
    rx_valid = 1'b0;
    rx_cost  = COST_ORTH;
    done     = 1'b0;

    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        bwd_nxt  = 1'b0;
        ph_nxt   = ST_C;
        x_nxt    = '0;
        y_nxt    = '0;
        idx_nxt  = '0;
        w_nxt    = w_in;
        h_nxt    = h_in;
      end
    end else begin
      unique case (ph_r)
        ST_C: begin
          rd_en   = 1'b1;
          rd_addr = idx_r;
          ph_nxt  = ST_A;
        end
        ST_A: begin
          rd_en   = 1'b1;
          rd_addr = n0;
          acc_nxt = rd_data;
          ph_nxt  = ST_B;
        end
        ST_B: begin
          rd_en    = 1'b1;
          rd_addr  = n1;
          rx_valid = v0;
          rx_cost  = COST_DIAG;
          acc_nxt  = rx_res;
          ph_nxt   = ST_D;
        end
        ST_D: begin
          rd_en    = 1'b1;
          rd_addr  = n2;
          rx_valid = v1;
          rx_cost  = COST_ORTH;
          acc_nxt  = rx_res;
          ph_nxt   = ST_E;
        end
        ST_E: begin
          rd_en    = 1'b1;
          rd_addr  = n3;
          rx_valid = v2;
          rx_cost  = COST_DIAG;
          acc_nxt  = rx_res;
          ph_nxt   = ST_W;
        end
        ST_W: begin
          rx_valid = v3;
          rx_cost  = COST_ORTH;
          wr_en    = 1'b1;
          ph_nxt   = ST_C;
          if (!bwd_r) begin
            idx_nxt = idx_r + AW'(1);
            if (x_last) begin
              x_nxt = '0;
              if (y_last) begin
                // last forward pixel is the first backward pixel
                bwd_nxt = 1'b1;
                idx_nxt = idx_r;
                x_nxt   = x_r;
              end else begin
                y_nxt = y_r + 9'd1;
              end
            end else begin
              x_nxt = x_r + 9'd1;
            end
          end else begin
            idx_nxt = idx_r - AW'(1);
            if (last_pix) begin
              busy_nxt = 1'b0;
              done     = 1'b1;
            end else if (x_first) begin
              x_nxt = w_r - 9'd1;
              y_nxt = y_r - 9'd1;
            end else begin
              x_nxt = x_r - 9'd1;
            end
          end
        end
        default: begin
          ph_nxt = ST_C;
        end
      endcase
    end
  end

  assign wr_addr = idx_r;
  assign wr_data = rx_res;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bwd_r  <= 1'b0;
      ph_r   <= ST_C;
    end else begin
      busy_r <= busy_nxt;
      bwd_r  <= bwd_nxt;
      ph_r   <= ph_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    w_r   <= w_nxt;
    h_r   <= h_nxt;
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
  end

endmodule

>>> design/chamfer_distance_transform_top.sv
// ----------------------------------------------------------------------------
// chamfer_distance_transform_top
// Chamfer 3-4 distance transform: pixel load, two raster passes, readout.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | in_req_type, in_pixel_set
// out     | output    | out_valid / out_stall  | out_distance, out_last_of_frame
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a load item writes one pixel; the load that fills the frame then holds
// in_stall while both raster passes run (6 memory steps per pixel in each pass)
// a read item passes through the registered memory port to the output register
// the output register lets the next item in while a result waits on out_stall
// rst_n is synchronous; the distance memory is not cleared
// ----------------------------------------------------------------------------
module chamfer_distance_transform_top
  import cdt_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic                  in_pixel_set,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_DIST_W-1:0] out_distance,
  output logic                  out_last_of_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_XFORM = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [DIM_W-1:0]      width_r, height_r;
  logic [POS_W-1:0]      lp_r, lp_nxt;
  logic [POS_W-1:0]      rp_r, rp_nxt;
  logic                  ready_r, ready_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  last_r, last_nxt;

  logic [DIM_W-1:0]      w_cur, h_cur;
  logic [2*DIM_W-1:0]    prod;
  logic [POS_W-1:0]      total;
  logic [POS_W-1:0]      lp_eff, lp_inc;
  logic                  in_acc, out_acc, out_free;
  logic                  seq_start;

  logic                  seq_busy, seq_done;
  logic                  seq_wr_en, seq_rd_en;
  logic [AW-1:0]         seq_wr_addr, seq_rd_addr;
  logic [DIST_BITS-1:0]  seq_wr_data;

  logic                  top_wr_en, top_rd_en;
  logic [DIST_BITS-1:0]  top_wr_data;

  logic                  ram_wr_en, ram_rd_en;
  logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
  logic [DIST_BITS-1:0]  ram_wr_data, ram_rd_data;
  logic [DIST_BITS+OUT_DIST_W-1:0] dist_ext;

  // clamp the configured size to 1..max
  always_comb begin
    if (width_r == '0) begin
      w_cur = 9'd1;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_cur = DIM_W'(MAX_WIDTH);
    end else begin
      w_cur = width_r;
    end
    if (height_r == '0) begin
      h_cur = 9'd1;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_cur = DIM_W'(MAX_HEIGHT);
    end else begin
      h_cur = height_r;
    end
    prod  = w_cur * h_cur;
    total = POS_W'(prod);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    lp_eff = ready_r ? '0 : lp_r;
    lp_inc = (lp_eff < POS_W'(DEPTH)) ? (lp_eff + POS_W'(1)) : lp_eff;
  end

  assign dist_ext = {{OUT_DIST_W{1'b0}}, ram_rd_data};

  always_comb begin
    state_nxt     = state_r;
    lp_nxt        = lp_r;
    rp_nxt        = rp_r;
    ready_nxt     = ready_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_dist_nxt  = out_dist_r;
    out_last_nxt  = out_last_r;
    top_wr_en     = 1'b0;
    top_rd_en     = 1'b0;
    top_wr_data   = in_pixel_set ? {DIST_BITS{1'b1}} : '0;
    seq_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_LOAD) begin
            top_wr_en = (lp_eff < POS_W'(DEPTH));
            lp_nxt    = lp_inc;
            if (ready_r) begin
              ready_nxt = 1'b0;
              rp_nxt    = '0;
            end
            if (lp_inc >= total) begin
              seq_start = 1'b1;
              state_nxt = S_XFORM;
            end
          end else if (ready_r) begin
            top_rd_en = 1'b1;
            state_nxt = S_RDATA;
            last_nxt  = ((rp_r + POS_W'(1)) >= total);
            if ((rp_r + POS_W'(1)) >= total) begin
              ready_nxt = 1'b0;
              lp_nxt    = '0;
              rp_nxt    = '0;
            end else begin
              rp_nxt = rp_r + POS_W'(1);
            end
          end
        end
      end
      S_XFORM: begin
        if (seq_done) begin
          ready_nxt = 1'b1;
          rp_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      S_RDATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_ext[OUT_DIST_W-1:0];
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lp_r        <= '0;
      rp_r        <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lp_r        <= lp_nxt;
      rp_r        <= rp_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r     <= last_nxt;
    out_dist_r <= out_dist_nxt;
    out_last_r <= out_last_nxt;
  end

  cdt_seq #(
    .DIST_BITS (DIST_BITS),
    .AW        (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (seq_start),
    .w_in    (w_cur),
    .h_in    (h_cur),
    .busy    (seq_busy),
    .done    (seq_done),
    .wr_en   (seq_wr_en),
    .wr_addr (seq_wr_addr),
    .wr_data (seq_wr_data),
    .rd_en   (seq_rd_en),
    .rd_addr (seq_rd_addr),
    .rd_data (ram_rd_data)
  );

  // memory port goes to the sequencer while a transform runs
  always_comb begin
    if (seq_busy) begin
      ram_wr_en   = seq_wr_en;
      ram_wr_addr = seq_wr_addr;
      ram_wr_data = seq_wr_data;
      ram_rd_en   = seq_rd_en;
      ram_rd_addr = seq_rd_addr;
    end else begin
      ram_wr_en   = top_wr_en;
      ram_wr_addr = lp_eff[AW-1:0];
      ram_wr_data = top_wr_data;
      ram_rd_en   = top_rd_en;
      ram_rd_addr = rp_r[AW-1:0];
    end
  end

  cdt_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_distance      = out_dist_r;
  assign out_last_of_frame = out_last_r;

endmodule
